[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

[src/ipt_pkg.sv]
// Package for the indexed priority table: constants, codes and shared types.
package ipt_pkg;

    localparam int CAPACITY_DEF       = 16;
    localparam int DATA_WIDTH_DEF     = 32;
    localparam int PRIORITY_WIDTH_DEF = 16;
    localparam int ORDER_WIDTH_DEF    = 32;

    localparam int SLOT_W    = 4;
    localparam int VALUE_W   = 32;
    localparam int PRI_OUT_W = 16;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_PROMOTE  = 2'd1,
        OP_POP_MAX  = 2'd2,
        OP_PEEK_MAX = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BAD_ID = 2'd3
    } status_t;

    typedef struct packed {
        op_t                 op;
        logic [SLOT_W-1:0]   slot_id;
        logic [VALUE_W-1:0]  item_value;
    } in_item_t;

    typedef struct packed {
        status_t               status;
        logic [SLOT_W-1:0]     slot_out;
        logic [VALUE_W-1:0]    value_out;
        logic [PRI_OUT_W-1:0]  priority_out;
        logic                  id_was_valid;
    } out_item_t;

    // Flags carried by the scan token from cell to cell.
    typedef struct packed {
        logic valid;
        logic free_found;
        logic best_found;
        logic id_valid;
    } token_ctl_t;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_ADD     = 2'd1,
        CMD_PROMOTE = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_COMMIT = 2'd2
    } state_t;

endpackage

[src/ipt_if.sv]
// Valid/ready channel interfaces for the input and result streams.
interface ipt_in_if import ipt_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ipt_out_if import ipt_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[src/ipt_cell.sv]
// One table slot: holds an entry and updates the scan token passing through.
module ipt_cell import ipt_pkg::*; #(
    parameter int IDX            = 0,
    parameter int IDX_W          = 4,
    parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
    parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF,
    parameter int ORDER_WIDTH    = ORDER_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [SLOT_W-1:0]         slot_id,
    input  token_ctl_t                ctl_in,
    input  logic [IDX_W-1:0]          free_slot_in,
    input  logic [IDX_W-1:0]          best_slot_in,
    input  logic [PRIORITY_WIDTH-1:0] best_pri_in,
    input  logic [ORDER_WIDTH-1:0]    best_ord_in,
    input  logic [DATA_WIDTH-1:0]     best_val_in,
    input  logic [PRIORITY_WIDTH-1:0] id_pri_in,
    input  logic [DATA_WIDTH-1:0]     id_val_in,
    output token_ctl_t                ctl_out,
    output logic [IDX_W-1:0]          free_slot_out,
    output logic [IDX_W-1:0]          best_slot_out,
    output logic [PRIORITY_WIDTH-1:0] best_pri_out,
    output logic [ORDER_WIDTH-1:0]    best_ord_out,
    output logic [DATA_WIDTH-1:0]     best_val_out,
    output logic [PRIORITY_WIDTH-1:0] id_pri_out,
    output logic [DATA_WIDTH-1:0]     id_val_out,
    input  cmd_t                      cmd,
    input  logic [IDX_W-1:0]          cmd_slot,
    input  logic [DATA_WIDTH-1:0]     cmd_val,
    input  logic [ORDER_WIDTH-1:0]    cmd_ord,
    input  logic [PRIORITY_WIDTH-1:0] cmd_pri
);

    localparam int CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic                      valid_reg;
    logic [PRIORITY_WIDTH-1:0] pri_reg;
    logic [ORDER_WIDTH-1:0]    ord_reg;
    logic [DATA_WIDTH-1:0]     val_reg;

    token_ctl_t                ctl_reg, ctl_next;
    logic [IDX_W-1:0]          free_reg, free_next;
    logic [IDX_W-1:0]          bslot_reg, bslot_next;
    logic [PRIORITY_WIDTH-1:0] bpri_reg, bpri_next;
    logic [ORDER_WIDTH-1:0]    bord_reg, bord_next;
    logic [DATA_WIDTH-1:0]     bval_reg, bval_next;
    logic [PRIORITY_WIDTH-1:0] ipri_reg, ipri_next;
    logic [DATA_WIDTH-1:0]     ival_reg, ival_next;

    logic better;
    logic id_hit;
    logic cmd_hit;

    assign id_hit  = (CMP_W'(slot_id) == CMP_W'(IDX));
    assign cmd_hit = (cmd_slot == MY_IDX);

    // Equal priorities go to the larger order; later slots win full ties, so an equal order replaces the running best.
    assign better = valid_reg &&
                    (!ctl_in.best_found || (pri_reg > best_pri_in) ||
                     ((pri_reg == best_pri_in) && (ord_reg >= best_ord_in)));

    always_comb
    begin
        ctl_next   = ctl_in;
        free_next  = free_slot_in;
        bslot_next = best_slot_in;
        bpri_next  = best_pri_in;
        bord_next  = best_ord_in;
        bval_next  = best_val_in;
        ipri_next  = id_pri_in;
        ival_next  = id_val_in;
        if (!valid_reg && !ctl_in.free_found)
        begin
            ctl_next.free_found = 1'b1;
            free_next           = MY_IDX;
        end
        if (better)
        begin
            ctl_next.best_found = 1'b1;
            bslot_next          = MY_IDX;
            bpri_next           = pri_reg;
            bord_next           = ord_reg;
            bval_next           = val_reg;
        end
        if (id_hit)
        begin
            ctl_next.id_valid = valid_reg;
            ipri_next         = pri_reg;
            ival_next         = val_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_reg  <= free_next;
        bslot_reg <= bslot_next;
        bpri_reg  <= bpri_next;
        bord_reg  <= bord_next;
        bval_reg  <= bval_next;
        ipri_reg  <= ipri_next;
        ival_reg  <= ival_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd_hit)
        begin
            unique case (cmd)
                CMD_ADD:   valid_reg <= 1'b1;
                CMD_CLEAR: valid_reg <= 1'b0;
                default:   valid_reg <= valid_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_hit)
        begin
            unique case (cmd)
                CMD_ADD:
                begin
                    pri_reg <= '0;
                    ord_reg <= cmd_ord;
                    val_reg <= cmd_val;
                end
                CMD_PROMOTE: pri_reg <= cmd_pri;
                default:     pri_reg <= pri_reg;
            endcase
        end
    end

    assign ctl_out       = ctl_reg;
    assign free_slot_out = free_reg;
    assign best_slot_out = bslot_reg;
    assign best_pri_out  = bpri_reg;
    assign best_ord_out  = bord_reg;
    assign best_val_out  = bval_reg;
    assign id_pri_out    = ipri_reg;
    assign id_val_out    = ival_reg;

endmodule

[src/indexed_priority_table_unit.sv]
// An op is accepted only while idle, and ops do not overlap: the scan token visits
// one slot cell per cycle along the chain, its result is captured once it leaves the end,
// and the table is updated and the result registered once the output register is free.
// A finished result waits in the output register while the next op is scanned.
// Reset (rst_n, asynchronous, active low) empties every slot and clears the
// insertion counter; no clearing pass is needed.
module indexed_priority_table_unit import ipt_pkg::*; #(
    parameter int CAPACITY       = CAPACITY_DEF,
    parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
    parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF,
    parameter int ORDER_WIDTH    = ORDER_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ipt_in_if.sink       in_ch,
    ipt_out_if.source    out_ch
);

    localparam int IDX_W = $clog2(CAPACITY);

    state_t state_reg, state_next;
    logic   launch_reg;
    logic   out_valid_reg;
    logic   out_free;
    logic   commit;
    logic   tok_done;

    in_item_t  item_reg;
    out_item_t out_reg;
    out_item_t res_out;

    token_ctl_t                res_ctl_reg;
    logic [IDX_W-1:0]          res_free_reg;
    logic [IDX_W-1:0]          res_bslot_reg;
    logic [PRIORITY_WIDTH-1:0] res_bpri_reg;
    logic [DATA_WIDTH-1:0]     res_bval_reg;
    logic [PRIORITY_WIDTH-1:0] res_ipri_reg;
    logic [DATA_WIDTH-1:0]     res_ival_reg;

    logic [ORDER_WIDTH-1:0]    cnt_reg;
    logic [ORDER_WIDTH-1:0]    cnt_inc;
    logic [PRIORITY_WIDTH-1:0] pri_inc;

    cmd_t                      cmd_raw, cmd_kind;
    logic [IDX_W-1:0]          cmd_slot;
    logic [DATA_WIDTH-1:0]     cmd_val;

    token_ctl_t                tok_ctl   [CAPACITY+1];
    logic [IDX_W-1:0]          tok_free  [CAPACITY+1];
    logic [IDX_W-1:0]          tok_bslot [CAPACITY+1];
    logic [PRIORITY_WIDTH-1:0] tok_bpri  [CAPACITY+1];
    logic [ORDER_WIDTH-1:0]    tok_bord  [CAPACITY+1];
    logic [DATA_WIDTH-1:0]     tok_bval  [CAPACITY+1];
    logic [PRIORITY_WIDTH-1:0] tok_ipri  [CAPACITY+1];
    logic [DATA_WIDTH-1:0]     tok_ival  [CAPACITY+1];

    assign tok_ctl[0]   = '{valid: launch_reg, default: 1'b0};
    assign tok_free[0]  = '0;
    assign tok_bslot[0] = '0;
    assign tok_bpri[0]  = '0;
    assign tok_bord[0]  = '0;
    assign tok_bval[0]  = '0;
    assign tok_ipri[0]  = '0;
    assign tok_ival[0]  = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        ipt_cell #(
            .IDX            (i),
            .IDX_W          (IDX_W),
            .DATA_WIDTH     (DATA_WIDTH),
            .PRIORITY_WIDTH (PRIORITY_WIDTH),
            .ORDER_WIDTH    (ORDER_WIDTH)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .slot_id       (item_reg.slot_id),
            .ctl_in        (tok_ctl[i]),
            .free_slot_in  (tok_free[i]),
            .best_slot_in  (tok_bslot[i]),
            .best_pri_in   (tok_bpri[i]),
            .best_ord_in   (tok_bord[i]),
            .best_val_in   (tok_bval[i]),
            .id_pri_in     (tok_ipri[i]),
            .id_val_in     (tok_ival[i]),
            .ctl_out       (tok_ctl[i+1]),
            .free_slot_out (tok_free[i+1]),
            .best_slot_out (tok_bslot[i+1]),
            .best_pri_out  (tok_bpri[i+1]),
            .best_ord_out  (tok_bord[i+1]),
            .best_val_out  (tok_bval[i+1]),
            .id_pri_out    (tok_ipri[i+1]),
            .id_val_out    (tok_ival[i+1]),
            .cmd           (cmd_kind),
            .cmd_slot      (cmd_slot),
            .cmd_val       (cmd_val),
            .cmd_ord       (cnt_inc),
            .cmd_pri       (pri_inc)
        );
    end

    assign tok_done = tok_ctl[CAPACITY].valid;
    assign out_free = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ch.ready = 1'b0;
        commit      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tok_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        pri_inc  = (res_ipri_reg == '1) ? res_ipri_reg : res_ipri_reg + 1'b1;
        cnt_inc  = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;
        cmd_val  = DATA_WIDTH'(item_reg.item_value);
        cmd_raw  = CMD_NONE;
        cmd_slot = res_free_reg;
        res_out              = '0;
        res_out.status       = ST_OK;
        res_out.id_was_valid = res_ctl_reg.id_valid;
        case (item_reg.op) inside
            OP_ADD:
            begin
                if (res_ctl_reg.free_found)
                begin
                    res_out.slot_out  = SLOT_W'(res_free_reg);
                    res_out.value_out = VALUE_W'(cmd_val);
                    cmd_raw           = CMD_ADD;
                end
                else
                begin
                    res_out.status = ST_FULL;
                end
            end
            OP_PROMOTE:
            begin
                if (res_ctl_reg.id_valid)
                begin
                    res_out.slot_out     = item_reg.slot_id;
                    res_out.value_out    = VALUE_W'(res_ival_reg);
                    res_out.priority_out = PRI_OUT_W'(pri_inc);
                    cmd_raw              = CMD_PROMOTE;
                    cmd_slot             = IDX_W'(item_reg.slot_id);
                end
                else
                begin
                    res_out.status = ST_BAD_ID;
                end
            end
            OP_POP_MAX, OP_PEEK_MAX:
            begin
                if (res_ctl_reg.best_found)
                begin
                    res_out.slot_out     = SLOT_W'(res_bslot_reg);
                    res_out.value_out    = VALUE_W'(res_bval_reg);
                    res_out.priority_out = PRI_OUT_W'(res_bpri_reg);
                    cmd_slot             = res_bslot_reg;
                    if (item_reg.op == OP_POP_MAX)
                    begin
                        cmd_raw = CMD_CLEAR;
                    end
                end
                else
                begin
                    res_out.status = ST_EMPTY;
                end
            end
            default: res_out.status = ST_OK;
        endcase
        cmd_kind = commit ? cmd_raw : CMD_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            launch_reg <= in_ch.valid && in_ch.ready;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd_kind == CMD_ADD)
            begin
                cnt_reg <= cnt_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg <= in_ch.payload;
        end
        if ((state_reg == S_SCAN) && tok_done)
        begin
            res_ctl_reg   <= tok_ctl[CAPACITY];
            res_free_reg  <= tok_free[CAPACITY];
            res_bslot_reg <= tok_bslot[CAPACITY];
            res_bpri_reg  <= tok_bpri[CAPACITY];
            res_bval_reg  <= tok_bval[CAPACITY];
            res_ipri_reg  <= tok_ipri[CAPACITY];
            res_ival_reg  <= tok_ival[CAPACITY];
        end
        if (commit)
        begin
            out_reg <= res_out;
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_reg;

endmodule

[src/ipt_checker.sv]
// Port-level assertions for the indexed priority table, bound to the top level.
`include "assert_macros.svh"

module ipt_checker import ipt_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_payload
);

    logic [1:0] pending_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_xfer && !out_xfer)
        begin
            pending_reg <= pending_reg + 2'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            pending_reg <= pending_reg - 2'd1;
        end
    end

    `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_payload), "result changed while stalled")
    `ASSERT_CLK(a_no_orphan, out_valid |-> pending_reg != 2'd0, "result without a pending op")
    `ASSERT_NEVER(a_pending_bound, pending_reg == 2'd3, "more than two ops in flight")
    `ASSERT_CLK(a_err_zero, out_valid && out_payload.status != ST_OK |-> out_payload.slot_out == '0 && out_payload.value_out == '0 && out_payload.priority_out == '0, "error result carries data")
    `ASSERT_CLK(a_bad_id, out_valid && out_payload.status == ST_BAD_ID |-> !out_payload.id_was_valid, "invalid id reported as valid")

endmodule

bind indexed_priority_table_unit ipt_checker u_ipt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_payload (out_ch.payload)
);
